// ===== rtl/volume_sample_diffuse_shade_unit_defines.svh =====
// Assertion macros used by the checker file of the shading unit.
`ifndef VOLUME_SAMPLE_DIFFUSE_SHADE_UNIT_DEFINES_SVH
`define VOLUME_SAMPLE_DIFFUSE_SHADE_UNIT_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define VSDS_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define VSDS_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/vsds_pkg.sv =====
// Package of the volume sample shading unit: widths, register codes, config type.
`timescale 1ns / 1ps
`default_nettype none
package vsds_pkg;

    localparam int GRAD_BITS  = 16;
    localparam int FRAC_BITS  = 15;
    localparam int LIGHT_BITS = 16;
    localparam int LIGHT_FRAC = 14;
    localparam int MAG_FRAC   = 7;
    localparam int CFG_W      = 16;
    localparam int SHADE_W    = 16;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    typedef enum logic [1:0] {
        REG_LIGHT_X = 2'd0,
        REG_LIGHT_Y = 2'd1,
        REG_LIGHT_Z = 2'd2,
        REG_AMBIENT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [LIGHT_BITS-1:0] light_x;
        logic signed [LIGHT_BITS-1:0] light_y;
        logic signed [LIGHT_BITS-1:0] light_z;
        logic        [CFG_W-1:0]      ambient_level;
    } t_cfg;

    localparam logic [LIGHT_BITS-1:0] RST_LIGHT_X = 16'hE000;
    localparam logic [LIGHT_BITS-1:0] RST_LIGHT_Y = 16'hE000;
    localparam logic [LIGHT_BITS-1:0] RST_LIGHT_Z = 16'hD2BF;
    localparam logic [CFG_W-1:0]      RST_AMBIENT = 16'd16384;

endpackage
`default_nettype wire

// ===== rtl/vsds_if.sv =====
// Stream interfaces of the shading unit: gradient samples in, shade words out.
`timescale 1ns / 1ps
`default_nettype none
interface vsds_in_if #(parameter int GRAD_BITS = vsds_pkg::GRAD_BITS);
    logic                        valid;
    logic                        ready;
    logic signed [GRAD_BITS-1:0] grad_x;
    logic signed [GRAD_BITS-1:0] grad_y;
    logic signed [GRAD_BITS-1:0] grad_z;

    modport source (output valid, output grad_x, output grad_y, output grad_z, input ready);
    modport sink   (input valid, input grad_x, input grad_y, input grad_z, output ready);
endinterface

interface vsds_out_if;
    logic                           valid;
    logic                           ready;
    logic [vsds_pkg::SHADE_W-1:0]   shade;
    logic                           zero_gradient;

    modport source (output valid, output shade, output zero_gradient, input ready);
    modport sink   (input valid, input shade, input zero_gradient, output ready);
endinterface
`default_nettype wire

// ===== rtl/vsds_front.sv =====
// Front stages: squares and light products, then sum of squares and |dot|.
`timescale 1ns / 1ps
`default_nettype none
module vsds_front #(
    parameter int GRAD_BITS = vsds_pkg::GRAD_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic signed [GRAD_BITS-1:0] i_grad_x,
    input  wire logic signed [GRAD_BITS-1:0] i_grad_y,
    input  wire logic signed [GRAD_BITS-1:0] i_grad_z,
    input  wire vsds_pkg::t_cfg              i_cfg,
    output logic                             o_valid,
    output logic [2*GRAD_BITS-1:0]           o_sumsq,
    output logic [GRAD_BITS+vsds_pkg::LIGHT_BITS-1:0] o_mag,
    output logic                             o_zero
);
    localparam int SQ_W   = 2*GRAD_BITS;
    localparam int PROD_W = GRAD_BITS + vsds_pkg::LIGHT_BITS;
    localparam int DOT_W  = PROD_W + 2;

    logic signed [SQ_W-1:0]   c_sq_x, c_sq_y, c_sq_z;
    logic signed [PROD_W-1:0] c_lp_x, c_lp_y, c_lp_z;
    logic [SQ_W-1:0]          r_sq_x, r_sq_y, r_sq_z;
    logic signed [PROD_W-1:0] r_lp_x, r_lp_y, r_lp_z;
    logic                     r_zero1, r_vld1;
    logic signed [DOT_W-1:0]  c_dot, c_abs;
    logic [SQ_W-1:0]          n_sumsq, r_sumsq;
    logic [PROD_W-1:0]        n_mag, r_mag;
    logic                     r_zero2, r_vld2;

    always_comb begin
        c_sq_x = i_grad_x * i_grad_x;
        c_sq_y = i_grad_y * i_grad_y;
        c_sq_z = i_grad_z * i_grad_z;
        c_lp_x = $signed(i_cfg.light_x) * i_grad_x;
        c_lp_y = $signed(i_cfg.light_y) * i_grad_y;
        c_lp_z = $signed(i_cfg.light_z) * i_grad_z;
    end

    always_comb begin
        n_sumsq = r_sq_x + r_sq_y + r_sq_z;
        c_dot   = DOT_W'(r_lp_x) + DOT_W'(r_lp_y) + DOT_W'(r_lp_z);
        c_abs   = c_dot[DOT_W-1] ? -c_dot : c_dot;
        n_mag   = c_abs[PROD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_x  <= c_sq_x;
            r_sq_y  <= c_sq_y;
            r_sq_z  <= c_sq_z;
            r_lp_x  <= c_lp_x;
            r_lp_y  <= c_lp_y;
            r_lp_z  <= c_lp_z;
            r_zero1 <= (i_grad_x == '0) && (i_grad_y == '0) && (i_grad_z == '0);
            r_sumsq <= n_sumsq;
            r_mag   <= n_mag;
            r_zero2 <= r_zero1;
        end
    end

    assign o_valid = r_vld2;
    assign o_sumsq = r_sumsq;
    assign o_mag   = r_mag;
    assign o_zero  = r_zero2;
endmodule
`default_nettype wire

// ===== rtl/vsds_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a carried sideband.
`timescale 1ns / 1ps
`default_nettype none
module vsds_sqrt #(
    parameter int IN_W   = 46,
    parameter int SIDE_W = 33
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [IN_W-1:0]   i_rad,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [IN_W/2-1:0]      o_root,
    output logic [SIDE_W-1:0]      o_side
);
    localparam int K = IN_W / 2;

    logic [IN_W-1:0]   r_rad  [K];
    logic [IN_W-1:0]   r_root [K];
    logic [SIDE_W-1:0] r_side [K];
    logic [K-1:0]      r_vld;
    logic [IN_W-1:0]   n_rad  [K];
    logic [IN_W-1:0]   n_root [K];

    always_comb begin
        logic [IN_W-1:0] c_rad_in, c_root_in, c_bit, c_trial;
        for (int j = 0; j < K; j++) begin
            c_rad_in  = (j == 0) ? i_rad : r_rad[(j == 0) ? 0 : j-1];
            c_root_in = (j == 0) ? '0    : r_root[(j == 0) ? 0 : j-1];
            c_bit     = IN_W'(1) << (2*(K-1-j));
            c_trial   = c_root_in + c_bit;
            if (c_rad_in >= c_trial) begin
                n_rad[j]  = c_rad_in - c_trial;
                n_root[j] = (c_root_in >> 1) + c_bit;
            end else begin
                n_rad[j]  = c_rad_in;
                n_root[j] = c_root_in >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[K-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < K; j++) begin
                r_rad[j]  <= n_rad[j];
                r_root[j] <= n_root[j];
                r_side[j] <= (j == 0) ? i_side : r_side[(j == 0) ? 0 : j-1];
            end
        end
    end

    assign o_valid = r_vld[K-1];
    assign o_root  = r_root[K-1][K-1:0];
    assign o_side  = r_side[K-1];
endmodule
`default_nettype wire

// ===== rtl/vsds_div.sv =====
// Pipelined restoring divider: overflow check stage, then one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module vsds_div #(
    parameter int MAG_W  = 32,
    parameter int ROOT_W = 23,
    parameter int Q_W    = 16,
    parameter int SHIFT  = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [MAG_W-1:0]  i_mag,
    input  wire logic [ROOT_W-1:0] i_root,
    input  wire logic              i_zero,
    output logic                   o_valid,
    output logic [Q_W-1:0]         o_quot,
    output logic                   o_ovf,
    output logic                   o_zero
);
    localparam int NW = MAG_W + SHIFT;
    localparam int DW = ((NW > ROOT_W + Q_W) ? NW : ROOT_W + Q_W) + 1;
    localparam int S  = Q_W + 1;

    logic [DW-1:0]     r_rem  [S];
    logic [ROOT_W-1:0] r_div  [S];
    logic [Q_W-1:0]    r_quot [S];
    logic [S-1:0]      r_ovf, r_zero, r_vld;
    logic [DW-1:0]     n_rem  [S];
    logic [Q_W-1:0]    n_quot [S];
    logic [DW-1:0]     c_num;

    assign c_num = DW'(i_mag) << SHIFT;

    always_comb begin
        logic [DW-1:0] c_dsh;
        n_rem[0]  = c_num;
        n_quot[0] = '0;
        for (int j = 1; j < S; j++) begin
            c_dsh     = DW'(r_div[j-1]) << (Q_W-j);
            n_quot[j] = r_quot[j-1];
            if (r_rem[j-1] >= c_dsh) begin
                n_rem[j]        = r_rem[j-1] - c_dsh;
                n_quot[j][Q_W-j] = 1'b1;
            end else begin
                n_rem[j] = r_rem[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[S-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div[0]  <= i_root;
            r_ovf[0]  <= c_num >= (DW'(i_root) << Q_W);
            r_zero[0] <= i_zero;
            for (int j = 0; j < S; j++) begin
                r_rem[j]  <= n_rem[j];
                r_quot[j] <= n_quot[j];
            end
            for (int j = 1; j < S; j++) begin
                r_div[j]  <= r_div[j-1];
                r_ovf[j]  <= r_ovf[j-1];
                r_zero[j] <= r_zero[j-1];
            end
        end
    end

    assign o_valid = r_vld[S-1];
    assign o_quot  = r_quot[S-1];
    assign o_ovf   = r_ovf[S-1];
    assign o_zero  = r_zero[S-1];
endmodule
`default_nettype wire

// ===== rtl/vsds_shade.sv =====
// Ambient blend: clamp, scale by (1 - ambient), add ambient, saturate; output register.
`timescale 1ns / 1ps
`default_nettype none
module vsds_shade #(
    parameter int FRAC_BITS = vsds_pkg::FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [FRAC_BITS:0]            i_quot,
    input  wire logic                          i_ovf,
    input  wire logic                          i_zero,
    input  wire logic [vsds_pkg::CFG_W-1:0]    i_ambient,
    output logic                               o_valid,
    output logic [vsds_pkg::SHADE_W-1:0]       o_shade,
    output logic                               o_zero
);
    localparam int Q_W = FRAC_BITS + 1;
    localparam int AW  = (Q_W > vsds_pkg::CFG_W) ? Q_W : vsds_pkg::CFG_W;
    localparam logic [Q_W-1:0] ONE   = Q_W'(1) << FRAC_BITS;
    localparam logic [AW-1:0]  ONE_A = AW'(1) << FRAC_BITS;

    logic [AW-1:0]      c_amb_w;
    logic [Q_W-1:0]     c_amb, c_d;
    logic [2*Q_W-1:0]   r_prod;
    logic [Q_W-1:0]     r_amb;
    logic               r_zero_a, r_vld_a;
    logic [Q_W:0]       c_sum;
    logic [Q_W-1:0]     n_shade;
    logic [vsds_pkg::SHADE_W-1:0] r_shade;
    logic               r_zero_b, r_vld_b;

    always_comb begin
        c_amb_w = AW'(i_ambient);
        c_amb   = Q_W'((c_amb_w > ONE_A) ? ONE_A : c_amb_w);
        c_d     = (i_ovf || (i_quot > ONE)) ? ONE : i_quot;
    end

    always_comb begin
        c_sum = (Q_W+1)'(r_amb) + (Q_W+1)'(r_prod >> FRAC_BITS);
        if (r_zero_a || (c_sum > (Q_W+1)'(ONE))) begin
            n_shade = ONE;
        end else begin
            n_shade = c_sum[Q_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= (ONE - c_amb) * c_d;
            r_amb    <= c_amb;
            r_zero_a <= i_zero;
            r_shade  <= vsds_pkg::SHADE_W'(n_shade);
            r_zero_b <= r_zero_a;
        end
    end

    assign o_valid = r_vld_b;
    assign o_shade = r_shade;
    assign o_zero  = r_zero_b;
endmodule
`default_nettype wire

// ===== rtl/volume_sample_diffuse_shade_unit.sv =====
// Top level of the volume sample diffuse shading unit: register port and pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Two-sided Lambertian shading factor for volume samples. Each input word carries a
// signed gradient (grad_x, grad_y, grad_z); each output word carries
// shade = ambient + (1 - ambient) * |L . g / |g|| in Q1.FRAC_BITS, saturated at 1.0,
// plus zero_gradient, which is set (with shade forced to 1.0) for an all-zero gradient.
// The light direction L (Q2.14, normalized by software) and the ambient level (Q1.15)
// sit in four APB registers at byte addresses 0, 4, 8 and 12; write them only while
// the pipeline is empty. The datapath is a fully pipelined chain: two front stages
// (products, then sum of squares and |dot|), one stage per bit of the square root
// (GRAD_BITS+7 stages), an overflow check plus one stage per quotient bit
// (FRAC_BITS+2 stages) and two blend stages. One word is taken every cycle while the
// output is not stalled. The whole chain advances together: it holds only while the
// output register is full and not taken, so the input is ready whenever the output is
// empty or being drained.
module volume_sample_diffuse_shade_unit #(
    parameter int GRAD_BITS = vsds_pkg::GRAD_BITS,
    parameter int FRAC_BITS = vsds_pkg::FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    vsds_in_if.sink                            i_smp,
    vsds_out_if.source                         o_shd,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vsds_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [vsds_pkg::DATA_W-1:0]   pwdata,
    output logic      [vsds_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);
    // Derived widths: squared magnitude, scaled radicand, |dot| and root.
    localparam int SQ_W   = 2*GRAD_BITS;
    localparam int RAD_W  = SQ_W + vsds_pkg::LIGHT_FRAC;
    localparam int MAG_W  = GRAD_BITS + vsds_pkg::LIGHT_BITS;
    localparam int ROOT_W = RAD_W / 2;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int SHIFT  = FRAC_BITS - vsds_pkg::MAG_FRAC;

    vsds_pkg::t_cfg r_cfg;
    vsds_pkg::t_reg_idx c_idx;

    logic                w_en;
    logic                w_f_vld, w_f_zero;
    logic [SQ_W-1:0]     w_f_sumsq;
    logic [MAG_W-1:0]    w_f_mag;
    logic                w_s_vld;
    logic [ROOT_W-1:0]   w_s_root;
    logic [MAG_W:0]      w_s_side;
    logic                w_d_vld, w_d_ovf, w_d_zero;
    logic [Q_W-1:0]      w_d_quot;
    logic                w_o_vld;

    // ---------------- configuration registers ----------------
    assign pready = 1'b1;
    assign c_idx  = vsds_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.light_x       <= vsds_pkg::RST_LIGHT_X;
            r_cfg.light_y       <= vsds_pkg::RST_LIGHT_Y;
            r_cfg.light_z       <= vsds_pkg::RST_LIGHT_Z;
            r_cfg.ambient_level <= vsds_pkg::RST_AMBIENT;
        end else if (psel && penable && pwrite) begin
            // Keep the low half of the write word; upper bits are dropped.
            case (c_idx)
                vsds_pkg::REG_LIGHT_X: r_cfg.light_x       <= pwdata[15:0];
                vsds_pkg::REG_LIGHT_Y: r_cfg.light_y       <= pwdata[15:0];
                vsds_pkg::REG_LIGHT_Z: r_cfg.light_z       <= pwdata[15:0];
                vsds_pkg::REG_AMBIENT: r_cfg.ambient_level <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (c_idx)
            vsds_pkg::REG_LIGHT_X: prdata = vsds_pkg::DATA_W'(r_cfg.light_x);
            vsds_pkg::REG_LIGHT_Y: prdata = vsds_pkg::DATA_W'(r_cfg.light_y);
            vsds_pkg::REG_LIGHT_Z: prdata = vsds_pkg::DATA_W'(r_cfg.light_z);
            vsds_pkg::REG_AMBIENT: prdata = vsds_pkg::DATA_W'(r_cfg.ambient_level);
            default:               prdata = '0;
        endcase
    end

    // ---------------- pipeline advance ----------------
    // Advance every stage when the output register is empty or its word is taken;
    // otherwise hold everything, so no word is lost or repeated.
    assign w_en        = !w_o_vld || o_shd.ready;
    assign i_smp.ready = w_en;

    vsds_front #(.GRAD_BITS(GRAD_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_smp.valid),
        .i_grad_x (i_smp.grad_x),
        .i_grad_y (i_smp.grad_y),
        .i_grad_z (i_smp.grad_z),
        .i_cfg    (r_cfg),
        .o_valid  (w_f_vld),
        .o_sumsq  (w_f_sumsq),
        .o_mag    (w_f_mag),
        .o_zero   (w_f_zero)
    );

    // Magnitude in Q.7: root of the sum of squares scaled by 2^14.
    // |dot| and the zero flag ride along as sideband.
    vsds_sqrt #(.IN_W(RAD_W), .SIDE_W(MAG_W+1)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_vld),
        .i_rad   (RAD_W'(w_f_sumsq) << vsds_pkg::LIGHT_FRAC),
        .i_side  ({w_f_zero, w_f_mag}),
        .o_valid (w_s_vld),
        .o_root  (w_s_root),
        .o_side  (w_s_side)
    );

    // d = floor(|dot| * 2^(FRAC_BITS-7) / root); overflow flags d above the quotient range.
    vsds_div #(.MAG_W(MAG_W), .ROOT_W(ROOT_W), .Q_W(Q_W), .SHIFT(SHIFT)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_vld),
        .i_mag   (w_s_side[MAG_W-1:0]),
        .i_root  (w_s_root),
        .i_zero  (w_s_side[MAG_W]),
        .o_valid (w_d_vld),
        .o_quot  (w_d_quot),
        .o_ovf   (w_d_ovf),
        .o_zero  (w_d_zero)
    );

    vsds_shade #(.FRAC_BITS(FRAC_BITS)) u_shade (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_d_vld),
        .i_quot    (w_d_quot),
        .i_ovf     (w_d_ovf),
        .i_zero    (w_d_zero),
        .i_ambient (r_cfg.ambient_level),
        .o_valid   (w_o_vld),
        .o_shade   (o_shd.shade),
        .o_zero    (o_shd.zero_gradient)
    );

    assign o_shd.valid = w_o_vld;
endmodule
`default_nettype wire

// ===== rtl/vsds_chk.sv =====
// Port checker of the shading unit and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "volume_sample_diffuse_shade_unit_defines.svh"
module vsds_chk #(
    parameter int FRAC_BITS = vsds_pkg::FRAC_BITS
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [vsds_pkg::SHADE_W-1:0] i_out_shade,
    input wire logic                        i_out_zero,
    input wire logic                        i_pready
);
    localparam logic [vsds_pkg::SHADE_W-1:0] ONE16 =
        vsds_pkg::SHADE_W'((33'd1 << FRAC_BITS) & 33'hFFFF);
    localparam bit WIDE = FRAC_BITS > 15;

    `VSDS_ASSERT_RST(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "output word dropped while stalled")
    `VSDS_ASSERT_RST(a_zero_one, i_clk, i_rst_n, i_out_valid && i_out_zero |-> i_out_shade == ONE16, "zero gradient without full shade")
    `VSDS_ASSERT_RST(a_shade_sat, i_clk, i_rst_n, i_out_valid |-> (WIDE || i_out_shade <= ONE16), "shade above one")
    `VSDS_ASSERT_RST(a_ready_empty, i_clk, i_rst_n, !i_out_valid |-> i_in_ready && i_pready, "input stalled with empty output")
    `VSDS_ASSERT(a_rst_clear, i_clk, !i_rst_n |=> !i_out_valid, "output valid right after reset")
endmodule

bind volume_sample_diffuse_shade_unit vsds_chk #(.FRAC_BITS(FRAC_BITS)) u_vsds_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_shd.valid),
    .i_out_ready (o_shd.ready),
    .i_out_shade (o_shd.shade),
    .i_out_zero  (o_shd.zero_gradient),
    .i_pready    (pready)
);
`default_nettype wire
